// ===== rtl/core/kbsl_pkg.sv =====
package kbsl_pkg;

   localparam int unsigned KEY_BYTES = 11;
   localparam int unsigned TEXT_W = 88;

   // Longest keyword length; longer load strings saturate to it.
   localparam logic [3:0] MAX_KEY_LEN = 4'd11;
   localparam logic [3:0] MIN_KEY_LEN_RESET = 4'd2;

   localparam logic [1:0] CSR_ENTRIES_IN_USE = 2'd0;
   localparam logic [1:0] CSR_MIN_KEY_LENGTH = 2'd1;
   localparam logic [1:0] CSR_IDENTIFIER_CODE = 2'd2;

   typedef enum logic [0:0] {
      OP_LOOKUP = 1'b0,
      OP_LOAD   = 1'b1
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [5:0]  entry_index;
      logic [63:0] text_head;
      logic [23:0] text_tail;
      logic [7:0]  text_length;
      logic [7:0]  load_code;
   } req_type;

   typedef struct packed {
      logic       is_keyword;
      logic [7:0] token_code;
   } rsp_type;

   typedef struct packed {
      logic [63:0] head;
      logic [23:0] tail;
      logic [3:0]  length;
      logic [7:0]  code;
   } entry_type;

   // One transaction as it moves down the search pipeline.
   typedef struct packed {
      op_type      operation;
      logic        load_ok;
      logic [5:0]  entry_index;
      logic [63:0] head;
      logic [23:0] tail;
      logic [3:0]  length;
      logic [7:0]  code;
      logic        hit;
   } item_type;

endpackage

// ===== rtl/core/kbsl_search_step.sv =====
module kbsl_search_step #(
   parameter int unsigned  TABLE_DEPTH = 64,
   parameter bit           FINAL_STEP  = 1'b0,
   localparam int unsigned NMAX        = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127,
   localparam int unsigned CNT_W       = $clog2(NMAX + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  kbsl_pkg::item_type        in_item,
   input  logic [CNT_W-1:0]          in_lo,
   input  logic [CNT_W-1:0]          in_hi,
   input  logic [CNT_W-1:0]          in_n,
   output logic                      out_valid,
   output kbsl_pkg::item_type        out_item,
   output logic [CNT_W-1:0]          out_lo,
   output logic [CNT_W-1:0]          out_hi,
   output logic [CNT_W-1:0]          out_n
);

   localparam int unsigned MEM_DEPTH = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;
   localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   function automatic logic [kbsl_pkg::TEXT_W-1:0] prefix_mask(input logic [3:0] nbytes);
      logic [kbsl_pkg::TEXT_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < kbsl_pkg::KEY_BYTES; i++) begin
         if (4'(i) < nbytes) begin
            mask[kbsl_pkg::TEXT_W-1-8*i -: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

   // Private copy of the table; loads write it as they pass this step.
   kbsl_pkg::entry_type mem [MEM_DEPTH];

   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] addr;
   kbsl_pkg::entry_type wr_entry;

   kbsl_pkg::entry_type rd_ff;
   logic               a_valid_ff;
   kbsl_pkg::item_type a_item_ff;
   logic [CNT_W-1:0]   a_lo_ff;
   logic [CNT_W-1:0]   a_hi_ff;
   logic [CNT_W-1:0]   a_n_ff;
   logic [CNT_W-1:0]   a_mid_ff;

   assign mid  = in_lo + ((in_hi - in_lo) >> 1);
   assign addr = FINAL_STEP ? in_lo : mid;

   assign wr_entry.head   = in_item.head;
   assign wr_entry.tail   = in_item.tail;
   assign wr_entry.length = in_item.length;
   assign wr_entry.code   = in_item.code;

   always_ff @(posedge clock) begin
      if (in_valid && (in_item.operation == kbsl_pkg::OP_LOAD) && in_item.load_ok) begin
         mem[in_item.entry_index[AW-1:0]] <= wr_entry;
      end
      rd_ff <= mem[addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_item_ff <= in_item;
      a_lo_ff   <= in_lo;
      a_hi_ff   <= in_hi;
      a_n_ff    <= in_n;
      a_mid_ff  <= mid;
   end

   // Compare the stored entry against the key. Bytes past the shorter length
   // are masked off, so an equal prefix falls back to the length order.
   logic [3:0]                  min_len;
   logic [kbsl_pkg::TEXT_W-1:0] mask;
   logic [kbsl_pkg::TEXT_W-1:0] ent_text;
   logic [kbsl_pkg::TEXT_W-1:0] key_text;
   logic                        prefix_eq;
   logic                        ent_lt;
   logic                        ent_eq;

   assign min_len   = (rd_ff.length < a_item_ff.length) ? rd_ff.length : a_item_ff.length;
   assign mask      = prefix_mask(min_len);
   assign ent_text  = {rd_ff.head, rd_ff.tail} & mask;
   assign key_text  = {a_item_ff.head, a_item_ff.tail} & mask;
   assign prefix_eq = (ent_text == key_text);
   assign ent_lt    = (ent_text < key_text) || (prefix_eq && (rd_ff.length < a_item_ff.length));
   assign ent_eq    = prefix_eq && (rd_ff.length == a_item_ff.length);

   logic               b_valid_ff;
   kbsl_pkg::item_type b_item_ff;
   kbsl_pkg::item_type b_item_in;
   logic [CNT_W-1:0]   b_lo_ff;
   logic [CNT_W-1:0]   b_lo_in;
   logic [CNT_W-1:0]   b_hi_ff;
   logic [CNT_W-1:0]   b_hi_in;
   logic [CNT_W-1:0]   b_n_ff;

   always_comb begin
      b_item_in = a_item_ff;
      b_lo_in   = a_lo_ff;
      b_hi_in   = a_hi_ff;
      if (FINAL_STEP) begin
         b_item_in.hit = (a_lo_ff < a_n_ff) && ent_eq;
         if (b_item_in.hit) begin
            b_item_in.code = rd_ff.code;
         end
      end else if (a_lo_ff < a_hi_ff) begin
         if (ent_lt) begin
            b_lo_in = a_mid_ff + 1'b1;
         end else begin
            b_hi_in = a_mid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_item_ff <= b_item_in;
      b_lo_ff   <= b_lo_in;
      b_hi_ff   <= b_hi_in;
      b_n_ff    <= a_n_ff;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;
   assign out_lo    = b_lo_ff;
   assign out_hi    = b_hi_ff;
   assign out_n     = b_n_ff;

endmodule

// ===== rtl/core/keyword_binary_search_lookup.sv =====
// Channel   Direction  Ports                                   Transaction
// request   in         start, busy, req_payload                start high, busy low
// response  out        rsp_valid, rsp_payload                  one strobed cycle
// config    in         csr_write_en, csr_index, csr_wdata      write enable high
//
// A transaction is taken in every cycle; busy is high only during reset and
// in the cycle after it. A request passes a registered entry stage, then one
// read-and-compare step pair per search level, each level holding its own
// copy of the table.
// Loads write each copy as they pass, so order with lookups is kept.
// Reset is synchronous and leaves the table as is; the receiver cannot stall.
module keyword_binary_search_lookup #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  kbsl_pkg::req_type   req_payload,
   output logic                rsp_valid,
   output kbsl_pkg::rsp_type   rsp_payload,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata
);

   localparam int unsigned NMAX = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
   localparam int unsigned CNT_W = $clog2(NMAX + 1);
   localparam int unsigned ITERS = CNT_W;
   localparam int unsigned MEM_DEPTH = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;

   logic       busy_ff;
   logic [6:0] entries_ff;
   logic [3:0] min_len_ff;
   logic [7:0] ident_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff    <= '0;
         min_len_ff    <= kbsl_pkg::MIN_KEY_LEN_RESET;
         ident_code_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            kbsl_pkg::CSR_ENTRIES_IN_USE:  entries_ff    <= csr_wdata[6:0];
            kbsl_pkg::CSR_MIN_KEY_LENGTH:  min_len_ff    <= csr_wdata[3:0];
            kbsl_pkg::CSR_IDENTIFIER_CODE: ident_code_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Entry stage: saturate the length, clamp the entry count and fold the
   // length range check into an empty search range.
   logic               accept;
   logic               len_too_long;
   logic               len_in_range;
   logic [CNT_W-1:0]   n_clamp;
   kbsl_pkg::item_type s0_item_in;
   logic [CNT_W-1:0]   s0_n_in;

   assign accept       = start && !busy_ff;
   assign len_too_long = req_payload.text_length > {4'b0, kbsl_pkg::MAX_KEY_LEN};
   assign len_in_range = (req_payload.text_length >= {4'b0, min_len_ff}) && !len_too_long;
   assign n_clamp      = (entries_ff > 7'(NMAX)) ? CNT_W'(NMAX) : CNT_W'(entries_ff);

   always_comb begin
      s0_item_in.operation   = req_payload.operation;
      s0_item_in.load_ok     = {1'b0, req_payload.entry_index} < 7'(MEM_DEPTH);
      s0_item_in.entry_index = req_payload.entry_index;
      s0_item_in.head        = req_payload.text_head;
      s0_item_in.tail        = req_payload.text_tail;
      s0_item_in.length      = len_too_long ? kbsl_pkg::MAX_KEY_LEN
                                            : req_payload.text_length[3:0];
      s0_item_in.code        = req_payload.load_code;
      s0_item_in.hit         = 1'b0;
      if ((req_payload.operation == kbsl_pkg::OP_LOOKUP) && len_in_range) begin
         s0_n_in = n_clamp;
      end else begin
         s0_n_in = '0;
      end
   end

   logic               chain_valid [ITERS+2];
   kbsl_pkg::item_type chain_item  [ITERS+2];
   logic [CNT_W-1:0]   chain_lo    [ITERS+2];
   logic [CNT_W-1:0]   chain_hi    [ITERS+2];
   logic [CNT_W-1:0]   chain_n     [ITERS+2];

   logic               s0_valid_ff;
   kbsl_pkg::item_type s0_item_ff;
   logic [CNT_W-1:0]   s0_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      s0_item_ff <= s0_item_in;
      s0_n_ff    <= s0_n_in;
   end

   assign chain_valid[0] = s0_valid_ff;
   assign chain_item[0]  = s0_item_ff;
   assign chain_lo[0]    = '0;
   assign chain_hi[0]    = s0_n_ff;
   assign chain_n[0]     = s0_n_ff;

   // ITERS narrowing levels, then one level that checks the lower bound.
   for (genvar k = 0; k <= ITERS; k++) begin : g_step
      kbsl_search_step #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .FINAL_STEP  (k == ITERS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_item   (chain_item[k]),
         .in_lo     (chain_lo[k]),
         .in_hi     (chain_hi[k]),
         .in_n      (chain_n[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1]),
         .out_lo    (chain_lo[k+1]),
         .out_hi    (chain_hi[k+1]),
         .out_n     (chain_n[k+1])
      );
   end

   kbsl_pkg::item_type fin_item;

   assign fin_item  = chain_item[ITERS+1];
   assign rsp_valid = chain_valid[ITERS+1] && (fin_item.operation == kbsl_pkg::OP_LOOKUP);
   assign rsp_payload.is_keyword = fin_item.hit;
   assign rsp_payload.token_code = fin_item.hit ? fin_item.code : ident_code_ff;

endmodule

// ===== rtl/core/kbsl_checker.sv =====
module kbsl_checker #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input kbsl_pkg::req_type req_payload,
   input logic              rsp_valid,
   input kbsl_pkg::rsp_type rsp_payload
);

   localparam int unsigned NMAX = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
   localparam int unsigned LAT = 2 * $clog2(NMAX + 1) + 3;

   logic lookup_acc;
   logic load_acc;
   logic long_acc;

   assign lookup_acc = start && !busy && (req_payload.operation == kbsl_pkg::OP_LOOKUP);
   assign load_acc   = start && !busy && (req_payload.operation == kbsl_pkg::OP_LOAD);
   assign long_acc   = lookup_acc &&
                       (req_payload.text_length > {4'b0, kbsl_pkg::MAX_KEY_LEN});

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   a_lookup_answers: assert property (@(posedge clock) disable iff (reset)
      lookup_acc |-> ##LAT rsp_valid)
      else $error("lookup transaction produced no response");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      load_acc |-> ##LAT !rsp_valid)
      else $error("load transaction produced a response");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(lookup_acc, LAT))
      else $error("response without a matching lookup");

   a_long_not_keyword: assert property (@(posedge clock) disable iff (reset)
      long_acc |-> ##LAT !rsp_payload.is_keyword)
      else $error("over-long identifier reported as keyword");

endmodule

bind keyword_binary_search_lookup kbsl_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_kbsl_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
